// ===== hdl/dcc_pkg.sv =====
package dcc_pkg;

    // Output scaling: chromaticity values carry this many fraction bits.
    localparam int FRAC_BITS = 16;

    // Temperature limits in kelvin.
    localparam logic [15:0] T_LOW  = 16'd4000;
    localparam logic [15:0] T_MID  = 16'd7000;
    localparam logic [15:0] T_HIGH = 16'd25000;

    // Polynomial coefficients scaled by one million. The cubic term is
    // negative in both sets and is kept as a magnitude already scaled by 1e9.
    localparam logic [63:0] C0N_LO = 64'd4607000000000000;
    localparam logic [63:0] C0N_HI = 64'd2006400000000000;
    localparam logic [21:0] C1_LO  = 22'd2967800;
    localparam logic [21:0] C1_HI  = 22'd1901800;
    localparam logic [17:0] C2_LO  = 18'd99110;
    localparam logic [17:0] C2_HI  = 18'd247480;
    localparam logic [17:0] C3_LO  = 18'd244063;
    localparam logic [17:0] C3_HI  = 18'd237040;

    localparam logic [19:0] MEGA = 20'd1000000;
    localparam logic [9:0]  KILO = 10'd1000;

    // Daylight locus constants in units of 2^-32.
    localparam logic [33:0] LOCUS_K1 = 34'd12326556140;
    localparam logic [31:0] LOCUS_K0 = 32'd1181116006;
    localparam logic [30:0] X_CAP    = 31'h66666666;

    // Pipeline geometry of the arithmetic back end.
    localparam int DIV_STEPS = 33;
    localparam int PRE_STGS  = 6;
    localparam int POST_STGS = 4;
    localparam int N_STGS    = PRE_STGS + DIV_STEPS + POST_STGS;

    localparam logic [15:0] FIELD_MAX = 16'hFFFF;

    // One classified temperature travelling from the front end to the back end.
    typedef struct packed {
        logic [15:0] temp;
        logic        oor;
        logic        hi;
    } t_item;

endpackage

// ===== hdl/dcc_front.sv =====
module dcc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [15:0]   i_temp_kelvin,
    output logic          o_push,
    output dcc_pkg::t_item o_item,
    input  logic          i_full
);

    logic           r_valid;
    dcc_pkg::t_item r_item;
    dcc_pkg::t_item n_item;

    // The held beat moves into the queue whenever the queue has room.
    assign o_push  = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;
    assign o_item  = r_item;

    // Classify the temperature: range check and coefficient set.
    always_comb begin
        n_item.temp = i_temp_kelvin;
        n_item.oor  = (i_temp_kelvin < dcc_pkg::T_LOW) || (i_temp_kelvin > dcc_pkg::T_HIGH);
        n_item.hi   = i_temp_kelvin > dcc_pkg::T_MID;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== hdl/dcc_queue.sv =====
module dcc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dcc_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_nempty,
    output dcc_pkg::t_item o_item
);

    dcc_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_full   = r_cnt == 2'd2;
    assign o_nempty = r_cnt != 2'd0;
    assign o_item   = r_mem[r_rp];

    // Two-entry queue with wrapping pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ===== hdl/dcc_back.sv =====
module dcc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_nempty,
    input  dcc_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [15:0]    o_chroma_x,
    output logic [15:0]    o_chroma_y,
    output logic           o_out_of_range
);

    localparam int NS = dcc_pkg::N_STGS;
    localparam int ND = dcc_pkg::DIV_STEPS;
    localparam int FB = dcc_pkg::FRAC_BITS;

    logic          en;
    logic [NS-1:0] r_v;
    logic [NS-1:0] r_oor;

    // Front stages: powers of T and the polynomial terms.
    logic [14:0] r1_t;
    logic [29:0] r1_t2;
    logic [36:0] r1_p1;
    logic [3:1]  r_hi;
    logic [44:0] r2_t3;
    logic [47:0] r2_p2;
    logic [56:0] r2_p1m;
    logic [62:0] r3_p3;
    logic [63:0] r3_den;
    logic [63:0] r3_p12;
    logic        r4_hi;
    logic [63:0] r4_p;
    logic [63:0] r4_den;
    logic        r5_pos;
    logic [63:0] r5_num;
    logic [63:0] r5_den;
    logic [63:0] r6_num;
    logic [63:0] r6_den;
    logic        r6_sat;

    // Restoring divider, one quotient bit a stage.
    logic [63:0] r_dr  [ND];
    logic [63:0] r_dd  [ND];
    logic [32:0] r_dq  [ND];
    logic        r_ds  [ND];
    logic [63:0] n_dr  [ND];
    logic [32:0] n_dq  [ND];

    // Back stages: rounding of x and the locus quadratic.
    logic [15:0] r7_xo;
    logic [30:0] r7_xq;
    logic [33:0] r7_u;
    logic [15:0] r8_xo;
    logic [47:0] r8_plo;
    logic [47:0] r8_phi;
    logic [15:0] r9_xo;
    logic [63:0] r9_y;
    logic [15:0] r_ox;
    logic [15:0] r_oy;

    logic [14:0] t15;
    logic [32:0] x33;
    logic [33:0] xo_full;
    logic [33:0] xo_half;
    logic [30:0] xq;
    logic [63:0] k0s;
    logic [63:0] ysub;
    logic [64:0] yo_full;
    logic [64:0] yo_half;
    logic [63:0] s5_num;

    // The whole pipeline advances together unless the output beat is held.
    assign en    = !r_v[NS-1] || i_ready;
    assign o_pop = en && i_nempty;
    assign t15   = i_item.temp[14:0];
    assign k0s   = {dcc_pkg::LOCUS_K0, 32'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NS-2:0], i_nempty};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_oor <= {r_oor[NS-2:0], i_item.oor};
        end
    end

    // Stages one to three: products, each registered before the next.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_t   <= t15;
            r1_t2  <= 30'(t15 * t15);
            r1_p1  <= 37'((i_item.hi ? dcc_pkg::C1_HI : dcc_pkg::C1_LO) * t15);
            r_hi[1] <= i_item.hi;
            r2_t3  <= 45'(r1_t2 * r1_t);
            r2_p2  <= 48'((r_hi[1] ? dcc_pkg::C2_HI : dcc_pkg::C2_LO) * r1_t2);
            r2_p1m <= 57'(r1_p1 * dcc_pkg::MEGA);
            r_hi[2] <= r_hi[1];
            r3_p3  <= 63'((r_hi[2] ? dcc_pkg::C3_HI : dcc_pkg::C3_LO) * r2_t3);
            r3_den <= 64'(r2_t3 * dcc_pkg::MEGA);
            r3_p12 <= 64'(r2_p1m) + 64'(r2_p2 * dcc_pkg::KILO);
            r_hi[3] <= r_hi[2];
        end
    end

    // Stages four to six: numerator sum, sign and overflow checks.
    assign s5_num = r4_p - (r4_hi ? dcc_pkg::C0N_HI : dcc_pkg::C0N_LO);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_p   <= r3_p12 + 64'(r3_p3);
            r4_den <= r3_den;
            r4_hi  <= r_hi[3];
            r5_pos <= r4_p > (r4_hi ? dcc_pkg::C0N_HI : dcc_pkg::C0N_LO);
            r5_num <= s5_num;
            r5_den <= r4_den;
            r6_sat <= r5_pos && (r5_num >= r5_den);
            r6_num <= (r5_pos && (r5_num < r5_den)) ? r5_num : 64'd0;
            r6_den <= r5_den;
        end
    end

    // Each divider stage doubles the remainder and subtracts where it can.
    always_comb begin
        logic [64:0] r2;
        logic [63:0] rin;
        logic [63:0] din;
        logic [32:0] qin;
        for (int d = 0; d < ND; d++) begin
            rin = (d == 0) ? r6_num : r_dr[(d == 0) ? 0 : d-1];
            din = (d == 0) ? r6_den : r_dd[(d == 0) ? 0 : d-1];
            qin = (d == 0) ? 33'd0  : r_dq[(d == 0) ? 0 : d-1];
            r2  = {rin, 1'b0};
            if (r2 >= {1'b0, din}) begin
                n_dr[d] = 64'(r2 - {1'b0, din});
                n_dq[d] = {qin[31:0], 1'b1};
            end else begin
                n_dr[d] = r2[63:0];
                n_dq[d] = {qin[31:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int d = 0; d < ND; d++) begin
                r_dr[d] <= n_dr[d];
                r_dq[d] <= n_dq[d];
                r_dd[d] <= (d == 0) ? r6_den : r_dd[(d == 0) ? 0 : d-1];
                r_ds[d] <= (d == 0) ? r6_sat : r_ds[(d == 0) ? 0 : d-1];
            end
        end
    end

    // Rounded x and the capped x from which y is formed.
    always_comb begin
        x33     = r_ds[ND-1] ? '1 : r_dq[ND-1];
        xo_full = (34'(x33) >> (32 - FB)) + 34'd1;
        xo_half = xo_full >> 1;
        xq      = (x33[32:1] > 32'(dcc_pkg::X_CAP)) ? dcc_pkg::X_CAP : x33[31:1];
    end

    // Locus y: the 31 by 34 bit product is split into two partial products.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_xo  <= (xo_half > 34'(dcc_pkg::FIELD_MAX)) ? dcc_pkg::FIELD_MAX : xo_half[15:0];
            r7_xq  <= xq;
            r7_u   <= dcc_pkg::LOCUS_K1 - 34'(3 * 34'(xq));
            r8_xo  <= r7_xo;
            r8_plo <= 48'(r7_xq * r7_u[16:0]);
            r8_phi <= 48'(r7_xq * r7_u[33:17]);
            r9_xo  <= r8_xo;
            r9_y   <= 64'(r8_plo) + (64'(r8_phi) << 17);
        end
    end

    always_comb begin
        ysub    = (r9_y < k0s) ? 64'd0 : r9_y - k0s;
        yo_full = (65'(ysub) >> (63 - FB)) + 65'd1;
        yo_half = yo_full >> 1;
    end

    // Output register: out-of-range beats show zero.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ox <= r_oor[NS-2] ? 16'd0 : r9_xo;
            if (r_oor[NS-2]) begin
                r_oy <= 16'd0;
            end else if (yo_half > 65'(dcc_pkg::FIELD_MAX)) begin
                r_oy <= dcc_pkg::FIELD_MAX;
            end else begin
                r_oy <= yo_half[15:0];
            end
        end
    end

    assign o_valid        = r_v[NS-1];
    assign o_chroma_x     = r_ox;
    assign o_chroma_y     = r_oy;
    assign o_out_of_range = r_oor[NS-1];

endmodule

// ===== hdl/daylight_cct_to_chromaticity.sv =====
// Channel | Handshake         | Payload
// in      | i_valid, o_ready  | i_temp_kelvin
// out     | o_valid, i_ready  | o_chroma_x, o_chroma_y, o_out_of_range
//
// One beat is accepted every cycle unless the front register holds a beat and the
// queue is full; a result passes through the front register, then the queue, then
// the 43-stage arithmetic pipe.
// The 33-stage restoring divider for x makes up most of that pipe.
// Reset clears all valid flags and the queue; payload registers are not reset.
// A held output freezes the arithmetic pipe; the front and the two-entry
// queue keep taking beats until the queue fills.
module daylight_cct_to_chromaticity (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_temp_kelvin,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_chroma_x,
    output logic [15:0] o_chroma_y,
    output logic        o_out_of_range
);

    logic           push;
    logic           full;
    logic           pop;
    logic           nempty;
    dcc_pkg::t_item f_item;
    dcc_pkg::t_item q_item;

    dcc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_temp_kelvin (i_temp_kelvin),
        .o_push        (push),
        .o_item        (f_item),
        .i_full        (full)
    );

    dcc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (f_item),
        .o_full   (full),
        .i_pop    (pop),
        .o_nempty (nempty),
        .o_item   (q_item)
    );

    dcc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_nempty       (nempty),
        .i_item         (q_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_chroma_x     (o_chroma_x),
        .o_chroma_y     (o_chroma_y),
        .o_out_of_range (o_out_of_range)
    );

endmodule

// ===== hdl/dcc_checker.sv =====
module dcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_chroma_x,
    input logic [15:0] o_chroma_y,
    input logic        o_out_of_range
);

    // No result beat follows a reset cycle.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result beat shown straight after reset");

    // Out-of-range beats carry zero chromaticity.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |-> o_chroma_x == 16'd0 && o_chroma_y == 16'd0)
        else $error("out-of-range beat with non-zero chromaticity");

    // In range, the daylight locus never reaches zero in x or y.
    a_inrange_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_of_range |-> o_chroma_x != 16'd0 && o_chroma_y != 16'd0)
        else $error("in-range beat with zero chromaticity");

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_chroma_x) && $stable(o_chroma_y)
        && $stable(o_out_of_range))
        else $error("stalled result beat changed");

endmodule

bind daylight_cct_to_chromaticity dcc_checker u_dcc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_chroma_x     (o_chroma_x),
    .o_chroma_y     (o_chroma_y),
    .o_out_of_range (o_out_of_range)
);

// ===== tb/daylight_cct_to_chromaticity_tb.sv =====
module daylight_cct_to_chromaticity_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LATENCY     = 45;
    localparam int  N_RANDOM    = 1030;
    localparam longint CYCLE_CAP = 400000;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic        oor;
    } t_chroma;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [15:0] i_temp_kelvin = '0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [15:0] o_chroma_x;
    logic [15:0] o_chroma_y;
    logic        o_out_of_range;

    logic [15:0] temp_queue[$];
    t_chroma     chroma_expected[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_off = 0;
    longint      cycle_count = 0;

    // Sampled i_valid and o_ready at the last rising edge, so the driver
    // knows whether the beat on offer was taken.
    logic o_ready_q = 1'b0;

    daylight_cct_to_chromaticity i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_temp_kelvin  (i_temp_kelvin),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_chroma_x     (o_chroma_x),
        .o_chroma_y     (o_chroma_y),
        .o_out_of_range (o_out_of_range)
    );

    always #5 i_clk = ~i_clk;

    // Saturate a rounded value to the 16-bit output field.
    function automatic logic [15:0] clamp16(logic [63:0] v);
        return (v > 64'(dcc_pkg::FIELD_MAX)) ? dcc_pkg::FIELD_MAX : v[15:0];
    endfunction

    // Daylight locus chromaticity of one temperature, computed exactly.
    function automatic t_chroma daylight_chroma(logic [15:0] temp);
        t_chroma     r;
        longint      a, b, c, d, t, num;
        logic [127:0] den, n, x33;
        logic [63:0] xq, u, y64, k0s, xo, yo;
        if (temp < dcc_pkg::T_LOW || temp > dcc_pkg::T_HIGH) begin
            r.x = '0;
            r.y = '0;
            r.oor = 1'b1;
            return r;
        end
        if (temp <= dcc_pkg::T_MID) begin
            a = -4607000; b = 2967800; c = 99110; d = 244063;
        end else begin
            a = -2006400; b = 1901800; c = 247480; d = 237040;
        end
        t = longint'(temp);
        num = a * 1000000000 + b * 1000000 * t + c * 1000 * t * t + d * t * t * t;
        den = 128'(1000000) * 128'(t * t * t);
        if (num <= 0) begin
            x33 = '0;
        end else if (128'(num) >= den) begin
            x33 = (128'd1 << 33) - 1;
        end else begin
            n = 128'(num) << 33;
            x33 = n / den;
        end
        xo = ((x33[63:0] >> (32 - dcc_pkg::FRAC_BITS)) + 64'd1) >> 1;
        xq = x33[63:0] >> 1;
        if (xq > 64'(dcc_pkg::X_CAP)) xq = 64'(dcc_pkg::X_CAP);
        u = 64'(dcc_pkg::LOCUS_K1) - 64'd3 * xq;
        y64 = xq * u;
        k0s = 64'(dcc_pkg::LOCUS_K0) << 32;
        y64 = (y64 < k0s) ? 64'd0 : y64 - k0s;
        yo = ((y64 >> (63 - dcc_pkg::FRAC_BITS)) + 64'd1) >> 1;
        r.x = clamp16(xo);
        r.y = clamp16(yo);
        r.oor = 1'b0;
        return r;
    endfunction

    // Driver: offer queued temperatures and drive i_ready at the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || o_ready_q) begin
                if (temp_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_temp_kelvin <= temp_queue.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= (hold_off == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, counted down once a cycle.
    always @(posedge i_clk) begin
        if (hold_off > 0) hold_off <= hold_off - 1;
    end

    // Predict on each accepted input beat; check each accepted output beat.
    always @(posedge i_clk) begin
        t_chroma e;
        cycle_count <= cycle_count + 1;
        o_ready_q <= i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready)
            chroma_expected.push_back(daylight_chroma(i_temp_kelvin));
        if (i_rst_n && o_valid && i_ready) begin
            if (chroma_expected.size() == 0) begin
                $display("%0t: unexpected beat x=%h y=%h oor=%b", $time,
                         o_chroma_x, o_chroma_y, o_out_of_range);
                mismatches++;
            end else begin
                e = chroma_expected.pop_front();
                if (o_chroma_x !== e.x) begin
                    $display("%0t: chroma_x expected %h actual %h", $time, e.x, o_chroma_x);
                    mismatches++;
                end
                if (o_chroma_y !== e.y) begin
                    $display("%0t: chroma_y expected %h actual %h", $time, e.y, o_chroma_y);
                    mismatches++;
                end
                if (o_out_of_range !== e.oor) begin
                    $display("%0t: out_of_range expected %b actual %b", $time, e.oor,
                             o_out_of_range);
                    mismatches++;
                end
            end
        end
        if (cycle_count > CYCLE_CAP) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Mostly in-range temperatures, some near the limits, some over the whole field.
    function automatic logic [15:0] random_temp();
        case ($urandom_range(9))
            0, 1:    return 16'($urandom_range(65535));
            2:       return 16'($urandom_range(dcc_pkg::T_MID - 2, dcc_pkg::T_MID + 2));
            3:       return 16'($urandom_range(dcc_pkg::T_LOW - 2, dcc_pkg::T_LOW + 2));
            4:       return 16'($urandom_range(dcc_pkg::T_HIGH - 2, dcc_pkg::T_HIGH + 2));
            default: return 16'($urandom_range(dcc_pkg::T_LOW, dcc_pkg::T_HIGH));
        endcase
    endfunction

    task automatic drain();
        while (temp_queue.size() != 0 || i_valid || chroma_expected.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] directed[$];
        int phase_send[4];
        int phase_recv[4];
        directed = '{16'd0, 16'd1, 16'd3999, 16'd4000, 16'd4001,
            16'd5500, 16'd6999, 16'd7000, 16'd7001, 16'd12345, 16'd24999,
            16'd25000, 16'd25001, 16'hFFFF, 16'h8000, 16'h5555, 16'hAAAA,
            16'd6500, 16'd20000};
        phase_send = '{0, 58, 0, 21};
        phase_recv = '{0, 0, 58, 21};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[k]) temp_queue.push_back(directed[k]);
        drain();
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = phase_send[p];
            recv_stall_pct = phase_recv[p];
            if (p == 0) hold_off = 200;
            for (int k = 0; k < N_RANDOM / 4; k++) temp_queue.push_back(random_temp());
            drain();
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && chroma_expected.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/dcc_pkg.sv
hdl/dcc_front.sv
hdl/dcc_queue.sv
hdl/dcc_back.sv
hdl/daylight_cct_to_chromaticity.sv
hdl/dcc_checker.sv
tb/daylight_cct_to_chromaticity_tb.sv
